// ===== sv/fcpr_pkg.sv =====
package fcpr_pkg;

   localparam logic [7:0] CHAR_U       = 8'h55;
   localparam logic [7:0] CHAR_N       = 8'h4E;
   localparam logic [7:0] CHAR_E       = 8'h45;
   localparam logic [7:0] CHAR_R       = 8'h52;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;

   localparam logic [7:0] CODE_ACK     = 8'h0D;
   localparam logic [7:0] CODE_ALIVE   = 8'hF0;
   localparam logic [7:0] CODE_CONFIG  = 8'hEE;
   localparam logic [7:0] CODE_UNKNOWN = 8'hDD;
   localparam logic [7:0] LEN_ACK      = 8'h03;
   localparam logic [7:0] LEN_UNKNOWN  = 8'h02;

   // xor of the fixed header bytes including the token
   localparam logic [7:0] HDR_CHECK = CHAR_U ^ CHAR_N ^ CHAR_E ^ CHAR_R ^ CHAR_COLON;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam int RSP_IDX_W = 4;
   localparam logic [RSP_IDX_W-1:0] RSP_LAST_ACK     = RSP_IDX_W'(8);
   localparam logic [RSP_IDX_W-1:0] RSP_LAST_UNKNOWN = RSP_IDX_W'(7);

   typedef enum logic [2:0] {
      PS_START   = 3'd0,
      PS_H1      = 3'd1,
      PS_H2      = 3'd2,
      PS_H3      = 3'd3,
      PS_LEN     = 3'd4,
      PS_TOKEN   = 3'd5,
      PS_PAYLOAD = 3'd6
   } parse_state_type;

   // one checked command on its way from the parser to the responder
   typedef struct packed {
      logic       valid;
      logic [7:0] cmd;
   } cmd_beat_type;

endpackage

// ===== sv/fcpr_front.sv =====
module fcpr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           rx_byte,
   output fcpr_pkg::cmd_beat_type push
);
   import fcpr_pkg::*;

   parse_state_type state_ff, state_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] frame_length_ff, frame_length_in;
   logic [7:0] running_check_ff, running_check_in;
   logic [7:0] command_ff, command_in;
   parse_state_type start_next;

   // a rejected byte is looked at again as a possible start byte
   assign start_next = (rx_byte == CHAR_U) ? PS_H1 : PS_START;

   always_comb begin
      state_in         = state_ff;
      bytes_left_in    = bytes_left_ff;
      frame_length_in  = frame_length_ff;
      running_check_in = running_check_ff;
      command_in       = command_ff;
      if (accept) begin
         case (state_ff)
            PS_H1: state_in = (rx_byte == CHAR_N) ? PS_H2 : start_next;
            PS_H2: state_in = (rx_byte == CHAR_E) ? PS_H3 : start_next;
            PS_H3: state_in = (rx_byte == CHAR_R) ? PS_LEN : start_next;
            PS_LEN: begin
               frame_length_in = rx_byte;
               state_in        = PS_TOKEN;
            end
            PS_TOKEN: begin
               if (rx_byte == CHAR_COLON) begin
                  running_check_in = HDR_CHECK ^ frame_length_ff;
                  bytes_left_in    = frame_length_ff;
                  state_in = (frame_length_ff == 8'd0) ? PS_START : PS_PAYLOAD;
               end else begin
                  state_in = start_next;
               end
            end
            PS_PAYLOAD: begin
               if (bytes_left_ff == frame_length_ff) command_in = rx_byte;
               if (bytes_left_ff > 8'd1) begin
                  running_check_in = running_check_ff ^ rx_byte;
                  bytes_left_in    = bytes_left_ff - 8'd1;
               end else begin
                  bytes_left_in = 8'd0;
                  state_in      = start_next;
               end
            end
            default: begin
               if (rx_byte == CHAR_U) running_check_in = 8'd0;
               state_in = start_next;
            end
         endcase
      end
   end

   always_comb begin
      push.valid = accept && (state_ff == PS_PAYLOAD) && (bytes_left_ff <= 8'd1)
                   && (running_check_ff == rx_byte);
      // with a length of one the checksum byte is also the command
      push.cmd   = (bytes_left_ff == frame_length_ff) ? rx_byte : command_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= PS_START;
         bytes_left_ff    <= 8'd0;
         frame_length_ff  <= 8'd0;
         running_check_ff <= 8'd0;
         command_ff       <= 8'd0;
      end else begin
         state_ff         <= state_in;
         bytes_left_ff    <= bytes_left_in;
         frame_length_ff  <= frame_length_in;
         running_check_ff <= running_check_in;
         command_ff       <= command_in;
      end
   end

endmodule

// ===== sv/fcpr_queue.sv =====
module fcpr_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  fcpr_pkg::cmd_beat_type push,
   input  logic                   pop,
   output fcpr_pkg::cmd_beat_type head,
   output logic                   full
);
   import fcpr_pkg::*;

   logic [7:0]          mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0] count_ff, count_in;

   function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
      logic [QUEUE_AW-1:0] r;
      r = (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_AW'(1);
      return r;
   endfunction

   assign full       = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push.valid ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) count_in = count_ff + QUEUE_CW'(1);
      else if (!push.valid && pop) count_in = count_ff - QUEUE_CW'(1);
   end

   always_ff @(posedge clock) begin
      if (push.valid) mem_ff[wr_ptr_ff] <= push.cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full) else $error("command pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid) else $error("command popped from an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CW'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

// ===== sv/fcpr_back.sv =====
module fcpr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  fcpr_pkg::cmd_beat_type head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_tx_byte,
   output logic                   rsp_last_byte
);
   import fcpr_pkg::*;

   logic [RSP_IDX_W-1:0] idx_ff, idx_in;
   logic                 valid_ff, valid_in;
   logic [7:0]           byte_ff;
   logic                 last_ff;
   logic                 is_ack;
   logic [7:0]           chk;
   logic [7:0]           cur_byte;
   logic                 cur_last;
   logic                 load;

   assign is_ack   = head.cmd inside {CODE_ALIVE, CODE_CONFIG};
   assign chk      = is_ack ? (HDR_CHECK ^ LEN_ACK ^ head.cmd ^ CODE_ACK)
                            : (HDR_CHECK ^ LEN_UNKNOWN ^ CODE_UNKNOWN);
   assign cur_last = (idx_ff == (is_ack ? RSP_LAST_ACK : RSP_LAST_UNKNOWN));

   always_comb begin
      case (idx_ff)
         4'd0:    cur_byte = CHAR_U;
         4'd1:    cur_byte = CHAR_N;
         4'd2:    cur_byte = CHAR_E;
         4'd3:    cur_byte = CHAR_R;
         4'd4:    cur_byte = is_ack ? LEN_ACK : LEN_UNKNOWN;
         4'd5:    cur_byte = CHAR_COLON;
         4'd6:    cur_byte = is_ack ? head.cmd : CODE_UNKNOWN;
         4'd7:    cur_byte = is_ack ? CODE_ACK : chk;
         default: cur_byte = chk;
      endcase
   end

   // the output register takes a new beat when empty or being drained
   assign load     = head.valid && (!valid_ff || !rsp_stall);
   assign pop      = load && cur_last;
   assign idx_in   = load ? (cur_last ? '0 : idx_ff + RSP_IDX_W'(1)) : idx_ff;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= cur_byte;
         last_ff <= cur_last;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_tx_byte   = byte_ff;
   assign rsp_last_byte = last_ff;

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= RSP_LAST_ACK) else $error("response index out of range");

   a_idx_restart: assert property (@(posedge clock) disable iff (reset)
      pop |=> idx_ff == '0) else $error("response index not restarted after last beat");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall) |=> valid_ff) else $error("stalled response beat dropped");

endmodule

// ===== sv/framed_command_parser_responder_core.sv =====
// Parses a received byte stream for framed commands (four header bytes, a length, a
// token, payload and an xor checksum) and answers every frame that checks out with a
// response frame of eight or nine bytes. The parser takes one byte per clock while req_stall
// is low; req_stall rises only while two checked commands are already waiting to be
// answered. Responses leave one beat per clock from a registered output while rsp_stall
// is low. Frames shorter than the response can therefore back up the command queue when
// they arrive with no gaps.
module framed_command_parser_responder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_last_byte
);
   import fcpr_pkg::*;

   cmd_beat_type push;
   cmd_beat_type head;
   logic         pop;
   logic         full;
   logic         accept;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   fcpr_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .push    (push)
   );

   fcpr_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (full)
   );

   fcpr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

// ===== bench/fcpr_reply_checker.sv =====
module fcpr_reply_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_tx_byte,
   input  logic       rsp_last_byte,
   input  logic       end_of_run,
   output int         fail_count,
   output int         pending_beats,
   output int         beats_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import fcpr_pkg::*;

   typedef struct packed {
      logic [7:0] tx;
      logic       last;
   } reply_beat_type;

   reply_beat_type  expected_reply_beats [$];
   reply_beat_type  oldest;
   parse_state_type hunt_state;
   logic [7:0]      bytes_to_go;
   logic [7:0]      frame_len;
   logic [7:0]      xor_so_far;
   logic [7:0]      command;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // one reply frame for the command just checked
   task automatic queue_reply();
      logic [7:0]     body [$];
      logic [7:0]     sum;
      reply_beat_type beat;
      body.push_back(CHAR_U);
      body.push_back(CHAR_N);
      body.push_back(CHAR_E);
      body.push_back(CHAR_R);
      if (command inside {CODE_ALIVE, CODE_CONFIG}) begin
         body.push_back(LEN_ACK);
         body.push_back(CHAR_COLON);
         body.push_back(command);
         body.push_back(CODE_ACK);
      end else begin
         body.push_back(LEN_UNKNOWN);
         body.push_back(CHAR_COLON);
         body.push_back(CODE_UNKNOWN);
      end
      sum = '0;
      foreach (body[i]) begin
         sum ^= body[i];
         beat.tx = body[i];
         beat.last = 1'b0;
         expected_reply_beats.push_back(beat);
      end
      beat.tx = sum;
      beat.last = 1'b1;
      expected_reply_beats.push_back(beat);
   endtask

   task automatic parse_rx_byte(input logic [7:0] b);
      bit again;
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         case (hunt_state)
            PS_H1: begin
               if (b == CHAR_N) hunt_state = PS_H2;
               else begin
                  hunt_state = PS_START;
                  again = 1'b1;
               end
            end
            PS_H2: begin
               if (b == CHAR_E) hunt_state = PS_H3;
               else begin
                  hunt_state = PS_START;
                  again = 1'b1;
               end
            end
            PS_H3: begin
               if (b == CHAR_R) hunt_state = PS_LEN;
               else begin
                  hunt_state = PS_START;
                  again = 1'b1;
               end
            end
            PS_LEN: begin
               frame_len = b;
               hunt_state = PS_TOKEN;
            end
            PS_TOKEN: begin
               if (b == CHAR_COLON) begin
                  xor_so_far = HDR_CHECK ^ frame_len;
                  bytes_to_go = frame_len;
                  hunt_state = (frame_len == 8'd0) ? PS_START : PS_PAYLOAD;
               end else begin
                  hunt_state = PS_START;
                  again = 1'b1;
               end
            end
            PS_PAYLOAD: begin
               if (bytes_to_go == frame_len) command = b;
               if (bytes_to_go > 8'd1) begin
                  xor_so_far ^= b;
                  bytes_to_go--;
               end else begin
                  // checksum byte, then looked at again as a start byte
                  bytes_to_go = '0;
                  hunt_state = PS_START;
                  if (xor_so_far == b) queue_reply();
                  again = 1'b1;
               end
            end
            default: begin
               if (b == CHAR_U) begin
                  hunt_state = PS_H1;
                  xor_so_far = '0;
               end else begin
                  hunt_state = PS_START;
               end
            end
         endcase
      end
   endtask

   initial begin
      fail_count = 0;
      beats_checked = 0;
      pending_beats = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         hunt_state = PS_START;
         bytes_to_go = '0;
         frame_len = '0;
         xor_so_far = '0;
         command = '0;
         expected_reply_beats.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reply_beats.size() == 0) begin
               report_mismatch($sformatf("reply beat %02h with nothing expected", rsp_tx_byte));
            end else begin
               oldest = expected_reply_beats.pop_front();
               if (rsp_tx_byte !== oldest.tx)
                  report_mismatch($sformatf("tx_byte %02h, want %02h", rsp_tx_byte, oldest.tx));
               if (rsp_last_byte !== oldest.last)
                  report_mismatch($sformatf("last_byte %b, want %b on byte %02h",
                                            rsp_last_byte, oldest.last, oldest.tx));
               beats_checked++;
            end
         end
         if (req_valid && !req_stall) parse_rx_byte(req_rx_byte);
         if (end_of_run && expected_reply_beats.size() != 0) begin
            report_mismatch($sformatf("%0d reply beats never arrived",
                                      expected_reply_beats.size()));
            expected_reply_beats.delete();
         end
      end
      pending_beats <= expected_reply_beats.size();
   end

endmodule

// ===== bench/tb_framed_command_parser_responder_core.sv =====
module tb_framed_command_parser_responder_core;
   timeunit 1ns;
   timeprecision 1ps;
   import fcpr_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASE_BYTES  = 12;

   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_SUM,
      FRAME_BROKEN
   } frame_kind_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_tx_byte;
   logic       rsp_last_byte;
   logic       end_of_run;

   int fail_count;
   int pending_beats;
   int beats_checked;
   int send_idle_pct;
   int recv_stall_pct;
   bit long_hold_req;
   int rx_bytes_sent;
   int frames_sent;
   int frame_bytes;
   int cycle_count;

   // checksum that doubles as a start byte, then a bad-checksum frame,
   // a zero-length frame after a repeated start byte, a length-one frame
   logic [7:0] opening_bytes [$] = {
      CHAR_U, CHAR_N, CHAR_E, CHAR_R, 8'h03, CHAR_COLON, CODE_ALIVE, 8'h90,
      HDR_CHECK ^ 8'h03 ^ CODE_ALIVE ^ 8'h90,
      CHAR_N, CHAR_E, CHAR_R, 8'h02, CHAR_COLON, 8'hFF, 8'h00,
      CHAR_U, CHAR_U, CHAR_N, CHAR_E, CHAR_R, 8'h00, CHAR_COLON,
      CHAR_U, CHAR_N, CHAR_E, CHAR_R, 8'h01, CHAR_COLON, HDR_CHECK ^ 8'h01
   };

   framed_command_parser_responder_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_last_byte (rsp_last_byte)
   );

   fcpr_reply_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_last_byte (rsp_last_byte),
      .end_of_run    (end_of_run),
      .fail_count    (fail_count),
      .pending_beats (pending_beats),
      .beats_checked (beats_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // receiver: random stall, or a long hold-off counted here
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            for (int k = 0; k < LONG_HOLD; k++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end else begin
            rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_rx_byte <= 8'($urandom);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      rx_bytes_sent++;
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0) @(posedge clock);
   endtask

   task automatic send_frame(input frame_kind_type kind);
      logic [7:0] fb [$];
      logic [7:0] len;
      logic [7:0] cmd;
      logic [7:0] sum;
      logic [7:0] pick;
      int         r;
      int         cut;
      r = $urandom_range(99);
      if (kind == FRAME_BROKEN) len = 8'($urandom_range(255));
      else if (r < 5) len = 8'd0;
      else if (r < 85) len = 8'($urandom_range(6, 1));
      else len = 8'($urandom_range(20, 7));
      case ($urandom_range(2))
         0: cmd = CODE_ALIVE;
         1: cmd = CODE_CONFIG;
         default: cmd = 8'($urandom);
      endcase
      fb.push_back(CHAR_U);
      fb.push_back(CHAR_N);
      fb.push_back(CHAR_E);
      fb.push_back(CHAR_R);
      fb.push_back(len);
      if (kind == FRAME_BROKEN) begin
         cut = $urandom_range(5, 1);
         for (int i = 0; i < cut; i++) send_byte(fb[i]);
         pick = 8'($urandom);
         if (pick == CHAR_COLON) pick = ~pick;
         send_byte(pick);
      end else begin
         fb.push_back(CHAR_COLON);
         sum = HDR_CHECK ^ len;
         if (len > 8'd1) begin
            fb.push_back(cmd);
            sum ^= cmd;
            for (int i = 0; i < int'(len) - 2; i++) begin
               pick = 8'($urandom);
               fb.push_back(pick);
               sum ^= pick;
            end
         end
         if (len != 8'd0) begin
            if (kind == FRAME_BAD_SUM) sum ^= 8'($urandom_range(255, 1));
            fb.push_back(sum);
         end
         foreach (fb[i]) send_byte(fb[i]);
         frames_sent++;
         frame_bytes += fb.size();
      end
   endtask

   task automatic random_traffic(input int target);
      int start;
      int r;
      start = frame_bytes;
      while (frame_bytes - start < target) begin
         r = $urandom_range(99);
         if (r < 65) send_frame(FRAME_GOOD);
         else if (r < 78) send_frame(FRAME_BAD_SUM);
         else if (r < 92) send_frame(FRAME_BROKEN);
         else begin
            repeat ($urandom_range(3, 1))
               send_byte(($urandom_range(3) == 0) ? CHAR_U : 8'($urandom));
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rx_byte <= '0;
      end_of_run <= 1'b0;
      long_hold_req = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      rx_bytes_sent = 0;
      frames_sent = 0;
      frame_bytes = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
      wait_drain();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = (p == 1) ? 62 : (p == 3) ? 10 : 0;
         recv_stall_pct = (p == 2) ? 62 : (p == 3) ? 10 : 0;
         random_traffic(PHASE_BYTES);
         wait_drain();
      end

      // receiver holds off while short frames keep coming, so the input backs up
      send_idle_pct = 0;
      recv_stall_pct = 0;
      long_hold_req = 1'b1;
      repeat (6) send_frame(FRAME_GOOD);
      wait_drain();

      repeat (DRAIN_CYCLES) @(posedge clock);
      end_of_run <= 1'b1;
      repeat (2) @(posedge clock);
      $display("covered %0d stream bytes, %0d frames, %0d reply beats checked",
               rx_bytes_sent, frames_sent, beats_checked);
      $display("phases: back-to-back, sender gaps, receiver stalls, mixed, long hold-off");
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/fcpr_pkg.sv
sv/fcpr_front.sv
sv/fcpr_queue.sv
sv/fcpr_back.sv
sv/framed_command_parser_responder_core.sv
bench/fcpr_reply_checker.sv
bench/tb_framed_command_parser_responder_core.sv
